@@ rtl/fts_pkg.sv @@
// Shared types and constants for the Fenwick prefix-sum tree.
package fts_pkg;

    localparam int IDX_W = 11;
    localparam int OUT_W = 32;
    localparam int DELTA_W = 32;
    localparam int OP_W = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE  = 2'd2;

    localparam logic [IDX_W-1:0] RESET_SIZE = 11'd1024;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic signed [DELTA_W-1:0] delta;
    } fts_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sum_value;
        logic                    index_error;
    } fts_result_t;

endpackage

@@ rtl/fts_ifs.sv @@
// Handshake interfaces for the request, response and configuration channels.
interface fts_req_if
    import fts_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic signed [DELTA_W-1:0] delta;

    modport source (output valid, output operation, output index_a, output index_b,
                    output delta, input ready);
    modport sink (input valid, input operation, input index_a, input index_b,
                  input delta, output ready);
endinterface

interface fts_rsp_if
    import fts_pkg::*;
    ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sum_value;
    logic                    index_error;

    modport source (output valid, output sum_value, output index_error, input ready);
    modport sink (input valid, input sum_value, input index_error, output ready);
endinterface

interface fts_cfg_if
    import fts_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/fts_ram.sv @@
// Single-port-write, single-port-read memory of partial sums with registered read data.
module fts_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [DW-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic signed [DW-1:0] rdata
);

    logic signed [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/fts_engine.sv @@
// Sequencer that walks Fenwick tree paths through the partial-sum memory.
module fts_engine
    import fts_pkg::*;
#(
    parameter int MAX_SIZE  = 1024,
    parameter int SUM_WIDTH = 32,
    parameter int AW        = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [IDX_W-1:0]            active_size,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fts_item_t                   item,
    output logic                        res_valid,
    input  logic                        res_ready,
    output fts_result_t                 res,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic signed [SUM_WIDTH-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic signed [SUM_WIDTH-1:0] mem_rdata
);

    localparam int IW = ($clog2(MAX_SIZE) + 2 > IDX_W) ? $clog2(MAX_SIZE) + 2 : IDX_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_QRY   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic                        pend_reg, pend_next;
    logic                        neg_reg, neg_next;
    logic                        phase_reg, phase_next;
    logic                        range_reg, range_next;
    logic                        err_reg, err_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               idx2_reg, idx2_next;
    logic [AW-1:0]               waddr_reg, waddr_next;
    logic signed [SUM_WIDTH-1:0] delta_reg, delta_next;
    logic signed [SUM_WIDTH-1:0] acc_reg, acc_next;

    logic [IW-1:0] size;
    logic [IW-1:0] ia;
    logic [IW-1:0] ib;
    logic [IW-1:0] ia_one;
    logic [IW-1:0] ia_clamp;
    logic [IW-1:0] ib_clamp;
    logic [IW-1:0] low;

    assign size = (IW'(active_size) > IW'(MAX_SIZE)) ? IW'(MAX_SIZE) : IW'(active_size);
    assign ia = IW'(item.index_a);
    assign ib = IW'(item.index_b);
    assign ia_one = (ia == '0) ? IW'(1) : ia;
    assign ia_clamp = (ia_one > size) ? size : ia_one;
    assign ib_clamp = (ib > size) ? size : ib;
    assign low = idx_reg & (~idx_reg + IW'(1));

    assign res.sum_value = OUT_W'(acc_reg);
    assign res.index_error = err_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pend_next  = pend_reg;
        neg_next   = neg_reg;
        phase_next = phase_reg;
        range_next = range_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        idx2_next  = idx2_reg;
        waddr_next = waddr_reg;
        delta_next = delta_reg;
        acc_next   = acc_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = waddr_reg;
        mem_wdata  = mem_rdata + delta_reg;
        mem_re     = 1'b0;
        mem_raddr  = AW'(idx_reg - IW'(1));

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    phase_next = 1'b0;
                    case (item.operation)
                        OP_ADD:
                        begin
                            if (ia == '0 || ia > size)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = ia;
                                delta_next = SUM_WIDTH'(item.delta);
                                state_next = S_ADD;
                            end
                        end
                        OP_PREFIX:
                        begin
                            idx_next   = (ia > size) ? size : ia;
                            err_next   = (ia > size);
                            range_next = 1'b0;
                            state_next = S_QRY;
                        end
                        OP_RANGE:
                        begin
                            idx_next   = ib_clamp;
                            idx2_next  = (ia_clamp == '0) ? '0 : ia_clamp - IW'(1);
                            err_next   = (ia == '0) || (ia_one > size) || (ib > size);
                            range_next = 1'b1;
                            state_next = S_QRY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                mem_we = pend_reg;
                if (idx_reg <= size)
                begin
                    mem_re     = 1'b1;
                    waddr_next = AW'(idx_reg - IW'(1));
                    pend_next  = 1'b1;
                    idx_next   = idx_reg + low;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_QRY:
            begin
                if (pend_reg)
                begin
                    acc_next = neg_reg ? acc_reg - mem_rdata : acc_reg + mem_rdata;
                end
                if (idx_reg != '0)
                begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    neg_next  = phase_reg;
                    idx_next  = idx_reg - low;
                end
                else if (range_reg && !phase_reg)
                begin
                    pend_next  = 1'b0;
                    phase_next = 1'b1;
                    idx_next   = idx2_reg;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            phase_reg <= 1'b0;
            range_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            neg_reg   <= neg_next;
            phase_reg <= phase_next;
            range_reg <= range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        idx_reg   <= idx_next;
        idx2_reg  <= idx2_next;
        waddr_reg <= waddr_next;
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
    end

endmodule

@@ rtl/fenwick_prefix_sum_tree_top.sv @@
// Top level of the Fenwick prefix-sum tree: config register, engine, memory, output register.
// One item is worked at a time; the single memory read port, one entry per cycle, sets the pace.
// After reset every memory entry is cleared before the first item is accepted.
// Reset sets active_size to 1024; configuration writes are accepted in every cycle.
module fenwick_prefix_sum_tree_top
    import fts_pkg::*;
#(
    parameter int MAX_SIZE  = 1024,
    parameter int SUM_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    fts_req_if.sink   req,
    fts_rsp_if.source rsp,
    fts_cfg_if.sink   cfg
);

    localparam int AW = $clog2(MAX_SIZE);

    logic [IDX_W-1:0]            active_size_reg;
    fts_item_t                   item;
    fts_result_t                 res;
    logic                        res_valid;
    logic                        res_ready;
    logic                        out_valid_reg;
    fts_result_t                 out_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic signed [SUM_WIDTH-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic signed [SUM_WIDTH-1:0] mem_rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= RESET_SIZE;
        end
        else if (cfg.valid)
        begin
            active_size_reg <= cfg.data;
        end
    end

    assign item.operation = req.operation;
    assign item.index_a   = req.index_a;
    assign item.index_b   = req.index_b;
    assign item.delta     = req.delta;

    fts_engine #(
        .MAX_SIZE  (MAX_SIZE),
        .SUM_WIDTH (SUM_WIDTH),
        .AW        (AW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .active_size (active_size_reg),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .item        (item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    fts_ram #(
        .DEPTH (MAX_SIZE),
        .AW    (AW),
        .DW    (SUM_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.sum_value   = out_reg.sum_value;
    assign rsp.index_error = out_reg.index_error;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("Memory read and write hit the same entry in one cycle.");

    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req.ready)
        else $error("Engine accepts an item while a result is pending.");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> rsp.valid)
        else $error("A handed-over result did not reach the output register.");

endmodule

@@ bench/tb_fenwick_prefix_sum_tree_top.sv @@
// Self-checking testbench for the Fenwick prefix-sum tree top level.
module tb_fenwick_prefix_sum_tree_top
    import fts_pkg::*;
    ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 115;
    localparam int RANDOM_PHASES = 8;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    class fenwick_scoreboard;
        bit [OUT_W-1:0] node_sums [1:TREE_DEPTH];
        bit [IDX_W-1:0] size_limit;
        fts_result_t    pending_sums [$];
        int             errors;

        function new();
            foreach (node_sums[i])
            begin
                node_sums[i] = '0;
            end
            size_limit = RESET_SIZE;
            errors = 0;
        endfunction

        function void set_size(input bit [IDX_W-1:0] value);
            size_limit = value;
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        function bit [OUT_W-1:0] prefix_total(input int unsigned x);
            bit [OUT_W-1:0] acc;
            acc = '0;
            while (x != 0)
            begin
                acc += node_sums[x];
                x -= x & (~x + 1);
            end
            return acc;
        endfunction

        function void note_item(input fts_item_t it);
            int unsigned es;
            int unsigned a;
            int unsigned b;
            bit          err;
            fts_result_t r;
            es = (size_limit > TREE_DEPTH) ? TREE_DEPTH : size_limit;
            a = it.index_a;
            b = it.index_b;
            err = 1'b0;
            case (it.operation)
                OP_ADD:
                begin
                    if (a == 0 || a > es)
                    begin
                        r.sum_value = '0;
                        r.index_error = 1'b1;
                        pending_sums.push_back(r);
                    end
                    else
                    begin
                        while (a <= es)
                        begin
                            node_sums[a] += it.delta;
                            a += a & (~a + 1);
                        end
                    end
                end
                OP_PREFIX:
                begin
                    if (a > es)
                    begin
                        err = 1'b1;
                        a = es;
                    end
                    r.sum_value = prefix_total(a);
                    r.index_error = err;
                    pending_sums.push_back(r);
                end
                OP_RANGE:
                begin
                    if (a == 0)
                    begin
                        err = 1'b1;
                        a = 1;
                    end
                    if (a > es)
                    begin
                        err = 1'b1;
                        a = es;
                    end
                    if (b > es)
                    begin
                        err = 1'b1;
                        b = es;
                    end
                    r.sum_value = prefix_total(b) - ((a == 0) ? '0 : prefix_total(a - 1));
                    r.index_error = err;
                    pending_sums.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(input fts_result_t got);
            fts_result_t want;
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result sum_value=%0d index_error=%0b",
                         $time, got.sum_value, got.index_error);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (got.sum_value !== want.sum_value)
            begin
                $display("%0t: sum_value expected %0d actual %0d",
                         $time, want.sum_value, got.sum_value);
                errors++;
            end
            if (got.index_error !== want.index_error)
            begin
                $display("%0t: index_error expected %0b actual %0b",
                         $time, want.index_error, got.index_error);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;

    fenwick_scoreboard sb;

    fts_req_if req_ch ();
    fts_rsp_if rsp_ch ();
    fts_cfg_if cfg_ch ();

    fenwick_prefix_sum_tree_top #(
        .MAX_SIZE  (TREE_DEPTH),
        .SUM_WIDTH (OUT_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int unsigned r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic fts_item_t make_item(input logic [OP_W-1:0] op, input int unsigned a,
                                            input int unsigned b, input logic [31:0] d);
        fts_item_t it;
        it.operation = op;
        it.index_a = IDX_W'(a);
        it.index_b = IDX_W'(b);
        it.delta = d;
        return it;
    endfunction

    function automatic int unsigned pick_index(input int unsigned es);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80 && es != 0)
        begin
            return $urandom_range(1, es);
        end
        if (r < 85)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return es;
        end
        if (r < 94)
        begin
            return es + 1;
        end
        return $urandom_range(0, 2047);
    endfunction

    function automatic fts_item_t random_item(input int unsigned es);
        fts_item_t   it;
        int unsigned r;
        logic [31:0] d;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            d = $urandom;
        end
        else if (r < 85)
        begin
            d = $urandom_range(0, 200) - 100;
        end
        else if (r < 90)
        begin
            d = 32'h7FFF_FFFF;
        end
        else if (r < 95)
        begin
            d = 32'h8000_0000;
        end
        else
        begin
            d = 32'hFFFF_FFFF;
        end
        r = $urandom_range(0, 99);
        if (r < 42)
        begin
            it = make_item(OP_ADD, pick_index(es), $urandom_range(0, 2047), d);
        end
        else if (r < 68)
        begin
            it = make_item(OP_PREFIX, pick_index(es), $urandom_range(0, 2047), d);
        end
        else if (r < 96)
        begin
            it = make_item(OP_RANGE, pick_index(es), pick_index(es), d);
        end
        else
        begin
            it = make_item(OP_NONE, pick_index(es), pick_index(es), d);
        end
        return it;
    endfunction

    task automatic send_item(input fts_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= it.operation;
        req_ch.index_a <= it.index_a;
        req_ch.index_b <= it.index_b;
        req_ch.delta <= it.delta;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(it);
    endtask

    task automatic run_random(input int count, input logic [IDX_W-1:0] size_value);
        int unsigned es;
        es = (size_value > TREE_DEPTH) ? TREE_DEPTH : size_value;
        for (int i = 0; i < count; i++)
        begin
            send_item(random_item(es));
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [IDX_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        sb.set_size(value);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_result('{sum_value: rsp_ch.sum_value, index_error: rsp_ch.index_error});
        end
    end

    initial
    begin
        fts_item_t        directed [$];
        logic [IDX_W-1:0] size_plan [$];
        rst_n = 1'b0;
        steady = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_ADD;
        req_ch.index_a = '0;
        req_ch.index_b = '0;
        req_ch.delta = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sb = new();

        directed.push_back(make_item(OP_PREFIX, 1024, 0, 0));
        directed.push_back(make_item(OP_ADD, 1, 0, 32'h7FFF_FFFF));
        directed.push_back(make_item(OP_ADD, 1024, 0, 32'h8000_0000));
        directed.push_back(make_item(OP_ADD, 0, 0, 5));
        directed.push_back(make_item(OP_ADD, 1025, 0, 9));
        directed.push_back(make_item(OP_ADD, 2047, 2047, 32'hFFFF_FFFF));
        directed.push_back(make_item(OP_ADD, 512, 0, 5));
        directed.push_back(make_item(OP_ADD, 1023, 0, -7));
        directed.push_back(make_item(OP_PREFIX, 0, 0, 0));
        directed.push_back(make_item(OP_PREFIX, 1, 0, 0));
        directed.push_back(make_item(OP_PREFIX, 512, 0, 0));
        directed.push_back(make_item(OP_PREFIX, 1024, 0, 0));
        directed.push_back(make_item(OP_PREFIX, 2047, 0, 0));
        directed.push_back(make_item(OP_RANGE, 1, 1024, 0));
        directed.push_back(make_item(OP_RANGE, 0, 1024, 0));
        directed.push_back(make_item(OP_RANGE, 1024, 1, 0));
        directed.push_back(make_item(OP_RANGE, 2047, 2047, 0));
        directed.push_back(make_item(OP_RANGE, 512, 512, 0));
        directed.push_back(make_item(OP_RANGE, 1000, 0, 0));
        directed.push_back(make_item(OP_ADD, 1, 0, 1));
        directed.push_back(make_item(OP_PREFIX, 1, 0, 0));
        directed.push_back(make_item(OP_RANGE, 2, 1023, 0));
        directed.push_back(make_item(OP_NONE, 2047, 2047, 32'hFFFF_FFFF));
        directed.push_back(make_item(OP_PREFIX, 1024, 0, 0));

        size_plan = '{11'd1, 11'd0, 11'd2047, 11'd1025, 11'd2, 11'd1024};
        for (int i = 0; i < RANDOM_PHASES; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                size_plan.push_back(IDX_W'($urandom_range(1, 16)));
            end
            else
            begin
                size_plan.push_back(IDX_W'($urandom_range(1, 2047)));
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i]);
        end
        run_random(PHASE_ITEMS, RESET_SIZE);

        foreach (size_plan[i])
        begin
            drain();
            write_size(size_plan[i]);
            steady = ($urandom_range(0, 3) == 0);
            run_random(PHASE_ITEMS, size_plan[i]);
        end

        drain();
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
